// ===== hdl/cor_pkg.sv =====
// ----------------------------------------------------------------------------
// cor_pkg: shared types and constants for circle overlap relaxation
// Field widths, register indexes, reset values, input word kinds and the unit
// status type used by the serial arithmetic units.
// ----------------------------------------------------------------------------
package cor_pkg;

  // Field widths
  localparam int POS_W      = 19;
  localparam int SLOT_W     = 4;
  localparam int RAD_W      = 8;
  localparam int AREA_W     = 12;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Largest stored position, signed Q11.8 by default
  localparam int POS_MAX    = 262143;

  // Parameter defaults
  localparam int MAX_BALLS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BALL_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BALL_COUNT  = 2'd3;

  // Register reset values
  localparam logic [RAD_W-1:0]  RADIUS_RST = 8'd40;
  localparam logic [AREA_W-1:0] WIDTH_RST  = 12'd1000;
  localparam logic [AREA_W-1:0] HEIGHT_RST = 12'd800;
  localparam logic [CNT_W-1:0]  COUNT_RST  = 5'd10;

  // Input word kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SWEEP = 1'b1;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ===== hdl/cor_mul.sv =====
// ----------------------------------------------------------------------------
// cor_mul: bit-serial unsigned multiplier
// Shift-and-add, one multiplier bit per cycle; product valid with done.
// ----------------------------------------------------------------------------
module cor_mul import cor_pkg::*; #(
  parameter int W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  output unit_sts_t        sts_o,
  output logic [2*W-1:0]   prod_o
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;
  logic [2*W-1:0] acc_q, mc_q;
  logic [W-1:0]   mp_q;

  // Count steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mc_q  <= {{W{1'b0}}, a_i};
      mp_q  <= b_i;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= {mc_q[2*W-2:0], 1'b0};
      mp_q <= {1'b0, mp_q[W-1:1]};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

// ===== hdl/cor_sqrt.sv =====
// ----------------------------------------------------------------------------
// cor_sqrt: digit-serial integer square root
// Restoring method, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module cor_sqrt import cor_pkg::*; #(
  parameter int SW = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SW-1:0]     rad_i,
  output unit_sts_t         sts_o,
  output logic [SW/2-1:0]   root_o
);

  localparam int RW = SW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;
  logic [SW-1:0]   rad_q;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [RW+3:0]   trial, tst, diff;

  // Trial subtract of the next root bit
  always_comb begin
    trial = {rem_q, rad_q[SW-1:SW-2]};
    tst   = {2'b00, root_q, 2'b01};
    diff  = trial - tst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in two radicand bits, keep or restore the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[SW-3:0], 2'b00};
      if (trial >= tst) begin
        rem_q  <= diff[RW+1:0];
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= trial[RW+1:0];
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;

endmodule

// ===== hdl/cor_div.sv =====
// ----------------------------------------------------------------------------
// cor_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module cor_div import cor_pkg::*; #(
  parameter int NW = 50,
  parameter int DW = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DW-1:0]   den_i,
  output unit_sts_t       sts_o,
  output logic [NW-1:0]   quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [NW-1:0] num_q, quo_q;
  logic [DW-1:0] den_q, rem_q;
  logic [DW:0]   r2, diff;

  // Bring down the next dividend bit and try the subtract
  always_comb begin
    r2   = {rem_q, num_q[NW-1]};
    diff = r2 - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      if (r2 >= {1'b0, den_q}) begin
        rem_q <= diff[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= r2[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

// ===== hdl/circle_overlap_relaxation.sv =====
// A load word is written to the store when accepted. A sweep visits n*(n-1)
// ordered pairs plus n skipped self pairs; a separated pair takes three serial
// multiplies, a touching pair five multiplies, a root and two divides over
// 2*MW bits, with MW = max(20, 9+FRAC_BITS); then each ball is emitted,
// holding while the output is stalled.
// Throughput: one word at a time. Reset: registers take defaults, stores undefined.
// ----------------------------------------------------------------------------
// circle_overlap_relaxation: pairwise ball overlap resolution
// Ball position store, pair sequencer and serial multiply, root and divide
// units; pushes touching balls apart and emits the resolved positions.
// ----------------------------------------------------------------------------
module circle_overlap_relaxation import cor_pkg::*; #(
  parameter int MAX_BALLS = MAX_BALLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // Input words
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic [SLOT_W-1:0]        slot_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  // Result words
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [SLOT_W-1:0]        out_slot_o,
  output logic signed [POS_W-1:0]  new_x_o,
  output logic signed [POS_W-1:0]  new_y_o,
  output logic                     last_o
);

  localparam int AW    = POS_W + 1;
  localparam int DF_W  = RAD_W + 1 + FRAC_BITS;
  localparam int MW    = (AW > DF_W) ? AW : DF_W;
  localparam int PW2   = 2 * MW;
  localparam int D2_W  = 2 * AW;
  localparam int NX_W  = MW + 2;
  localparam int IW    = $clog2(MAX_BALLS);
  localparam int LIM_W = AREA_W + 2;

  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_PAIR = 20'h00002,
    ST_RDI  = 20'h00004,
    ST_RDJ  = 20'h00008,
    ST_DIFF = 20'h00010,
    ST_ABS  = 20'h00020,
    ST_SQX  = 20'h00040,
    ST_SQY  = 20'h00080,
    ST_LIM  = 20'h00100,
    ST_CHK  = 20'h00200,
    ST_SQRT = 20'h00400,
    ST_MULX = 20'h00800,
    ST_DIVX = 20'h01000,
    ST_MULY = 20'h02000,
    ST_DIVY = 20'h04000,
    ST_WRI  = 20'h08000,
    ST_WRJ  = 20'h10000,
    ST_NEXT = 20'h20000,
    ST_ERD  = 20'h40000,
    ST_ELD  = 20'h80000
  } state_e;

  // Wall test for one axis
  function automatic logic axis_out(input logic signed [NX_W-1:0] p,
                                    input logic signed [LIM_W-1:0] lim);
    logic signed [NX_W-1:0] pmax, lo, lime, pp;
    pmax = NX_W'(POS_MAX);
    lo   = p + NX_W'(2 ** FRAC_BITS);
    lime = {{(NX_W-LIM_W){lim[LIM_W-1]}}, lim};
    pp   = p[NX_W-1] ? '0 : (p >>> FRAC_BITS);
    return (p > pmax) || (lo <= 0) || (pp > lime);
  endfunction

  // Configuration registers
  logic [RAD_W-1:0]  ball_radius_q;
  logic [AREA_W-1:0] area_width_q, area_height_q;
  logic [CNT_W-1:0]  ball_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ball_radius_q <= RADIUS_RST;
      area_width_q  <= WIDTH_RST;
      area_height_q <= HEIGHT_RST;
      ball_count_q  <= COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BALL_RADIUS: ball_radius_q <= cfg_data_i[RAD_W-1:0];
        CFG_AREA_WIDTH:  area_width_q  <= cfg_data_i[AREA_W-1:0];
        CFG_AREA_HEIGHT: area_height_q <= cfg_data_i[AREA_W-1:0];
        CFG_BALL_COUNT:  ball_count_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived limits
  logic [DF_W-1:0]         dfull;
  logic signed [LIM_W-1:0] lim_x, lim_y;
  logic [6:0]              nb_cap, nb;

  always_comb begin
    dfull  = {ball_radius_q, 1'b0, {FRAC_BITS{1'b0}}};
    lim_x  = $signed({2'b00, area_width_q}) - $signed({5'b00000, ball_radius_q, 1'b0});
    lim_y  = $signed({2'b00, area_height_q}) - $signed({5'b00000, ball_radius_q, 1'b0});
    nb_cap = ({2'b00, ball_count_q} > 7'd16) ? 7'd16 : {2'b00, ball_count_q};
    nb     = (nb_cap > 7'(MAX_BALLS)) ? 7'(MAX_BALLS) : nb_cap;
  end

  // Handshakes
  logic in_acc, out_acc, out_valid_q;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  // Ball position store
  logic [POS_W-1:0] mem_x_q [MAX_BALLS];
  logic [POS_W-1:0] mem_y_q [MAX_BALLS];
  logic [POS_W-1:0] rd_x_q, rd_y_q, mem_wx, mem_wy;
  logic [IW-1:0]    mem_wa, mem_ra;
  logic             mem_we, mem_re;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x_q[mem_wa] <= mem_wx;
      mem_y_q[mem_wa] <= mem_wy;
    end
    if (mem_re) begin
      rd_x_q <= mem_x_q[mem_ra];
      rd_y_q <= mem_y_q[mem_ra];
    end
  end

  // Serial units
  unit_sts_t         mul_sts, sqrt_sts, div_sts;
  logic              mul_start, sqrt_start, div_start;
  logic [MW-1:0]     mul_a, mul_b;
  logic [PW2-1:0]    mul_p, div_q;
  logic [AW-1:0]     sqrt_root;

  logic [D2_W-1:0]   d2_q;
  logic [AW-1:0]     d_q;

  cor_mul #(.W(MW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sts_o   (mul_sts),
    .prod_o  (mul_p)
  );

  cor_sqrt #(.SW(D2_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (d2_q),
    .sts_o   (sqrt_sts),
    .root_o  (sqrt_root)
  );

  cor_div #(.NW(PW2), .DW(AW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_p),
    .den_i   (d_q),
    .sts_o   (div_sts),
    .quo_o   (div_q)
  );

  // Pair datapath registers
  state_e                  state_q, state_d;
  logic                    go_q, go_d;
  logic [IW-1:0]           i_q, i_d, j_q, j_d, last_q, last_d;
  logic [POS_W-1:0]        xi_q, yi_q, xj_q, yj_q;
  logic [AW-1:0]           ax_q, ay_q;
  logic                    sx_q, sy_q;
  logic [D2_W-1:0]         sqx_q;
  logic [PW2-1:0]          lim2_q;
  logic [MW-1:0]           ov_q, mx_q, my_q;
  logic                    out_ld;

  logic signed [AW-1:0]    dx, dy;
  logic signed [MW:0]      smx, smy;
  logic signed [NX_W-1:0]  nxi, nyi, nxj, nyj;
  logic                    hit_i, hit_j;

  // Differences and moved positions
  always_comb begin
    dx    = $signed({xi_q[POS_W-1], xi_q}) - $signed({xj_q[POS_W-1], xj_q});
    dy    = $signed({yi_q[POS_W-1], yi_q}) - $signed({yj_q[POS_W-1], yj_q});
    smx   = sx_q ? -$signed({1'b0, mx_q}) : $signed({1'b0, mx_q});
    smy   = sy_q ? -$signed({1'b0, my_q}) : $signed({1'b0, my_q});
    nxi   = $signed({{(NX_W-POS_W){xi_q[POS_W-1]}}, xi_q}) + $signed({smx[MW], smx});
    nyi   = $signed({{(NX_W-POS_W){yi_q[POS_W-1]}}, yi_q}) + $signed({smy[MW], smy});
    nxj   = $signed({{(NX_W-POS_W){xj_q[POS_W-1]}}, xj_q}) - $signed({smx[MW], smx});
    nyj   = $signed({{(NX_W-POS_W){yj_q[POS_W-1]}}, yj_q}) - $signed({smy[MW], smy});
    hit_i = axis_out(nxi, lim_x) || axis_out(nyi, lim_y);
    hit_j = axis_out(nxj, lim_x) || axis_out(nyj, lim_y);
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    go_d       = go_q;
    i_d        = i_q;
    j_d        = j_q;
    last_d     = last_q;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mul_a      = MW'(ax_q);
    mul_b      = MW'(ax_q);
    mem_we     = 1'b0;
    mem_wa     = i_q;
    mem_wx     = nxi[POS_W-1:0];
    mem_wy     = nyi[POS_W-1:0];
    mem_re     = 1'b0;
    mem_ra     = i_q;
    out_ld     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_LOAD) begin
            if ({3'b000, slot_i} < 7'(MAX_BALLS)) begin
              mem_we = 1'b1;
              mem_wa = IW'(slot_i);
              mem_wx = pos_x_i;
              mem_wy = pos_y_i;
            end
          end else if (nb != 7'd0) begin
            last_d  = IW'(nb - 7'd1);
            i_d     = '0;
            j_d     = '0;
            state_d = ST_PAIR;
          end
        end
      end
      ST_PAIR: begin
        state_d = (i_q == j_q) ? ST_NEXT : ST_RDI;
      end
      ST_RDI: begin
        mem_re  = 1'b1;
        mem_ra  = i_q;
        state_d = ST_RDJ;
      end
      ST_RDJ: begin
        mem_re  = 1'b1;
        mem_ra  = j_q;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        state_d = ST_ABS;
      end
      ST_ABS: begin
        state_d = ST_SQX;
      end
      ST_SQX: begin
        mul_a = MW'(ax_q);
        mul_b = MW'(ax_q);
        if (!go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b1;
        end else if (mul_sts.done) begin
          go_d    = 1'b0;
          state_d = ST_SQY;
        end
      end
      ST_SQY: begin
        mul_a = MW'(ay_q);
        mul_b = MW'(ay_q);
        if (!go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b1;
        end else if (mul_sts.done) begin
          go_d    = 1'b0;
          state_d = ST_LIM;
        end
      end
      ST_LIM: begin
        mul_a = MW'(dfull);
        mul_b = MW'(dfull);
        if (!go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b1;
        end else if (mul_sts.done) begin
          go_d    = 1'b0;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        // Drop coincident and separated pairs
        if (d2_q == '0 || {{(PW2-D2_W){1'b0}}, d2_q} > lim2_q) begin
          state_d = ST_NEXT;
        end else begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!go_q) begin
          sqrt_start = 1'b1;
          go_d       = 1'b1;
        end else if (sqrt_sts.done) begin
          go_d    = 1'b0;
          state_d = ST_MULX;
        end
      end
      ST_MULX: begin
        mul_a = ov_q;
        mul_b = MW'(ax_q);
        if (!go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b1;
        end else if (mul_sts.done) begin
          go_d    = 1'b0;
          state_d = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (!go_q) begin
          div_start = 1'b1;
          go_d      = 1'b1;
        end else if (div_sts.done) begin
          go_d    = 1'b0;
          state_d = ST_MULY;
        end
      end
      ST_MULY: begin
        mul_a = ov_q;
        mul_b = MW'(ay_q);
        if (!go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b1;
        end else if (mul_sts.done) begin
          go_d    = 1'b0;
          state_d = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (!go_q) begin
          div_start = 1'b1;
          go_d      = 1'b1;
        end else if (div_sts.done) begin
          go_d    = 1'b0;
          state_d = ST_WRI;
        end
      end
      ST_WRI: begin
        // Keep ball i in place on a wall hit
        mem_we  = !hit_i;
        mem_wa  = i_q;
        mem_wx  = nxi[POS_W-1:0];
        mem_wy  = nyi[POS_W-1:0];
        state_d = ST_WRJ;
      end
      ST_WRJ: begin
        mem_we  = !hit_j;
        mem_wa  = j_q;
        mem_wx  = nxj[POS_W-1:0];
        mem_wy  = nyj[POS_W-1:0];
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (j_q == last_q) begin
          if (i_q == last_q) begin
            i_d     = '0;
            state_d = ST_ERD;
          end else begin
            i_d     = i_q + 1'b1;
            j_d     = '0;
            state_d = ST_PAIR;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_PAIR;
        end
      end
      ST_ERD: begin
        mem_re  = 1'b1;
        mem_ra  = i_q;
        state_d = ST_ELD;
      end
      ST_ELD: begin
        // Hold until the output register is free
        if (!out_valid_q || out_acc) begin
          out_ld = 1'b1;
          if (i_q == last_q) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      i_q     <= i_d;
      j_q     <= j_d;
      last_q  <= last_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture operands and unit results
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RDJ) begin
      xi_q <= rd_x_q;
      yi_q <= rd_y_q;
    end
    if (state_q == ST_DIFF) begin
      xj_q <= rd_x_q;
      yj_q <= rd_y_q;
    end
    if (state_q == ST_ABS) begin
      sx_q <= dx[AW-1];
      sy_q <= dy[AW-1];
      ax_q <= dx[AW-1] ? AW'(-dx) : AW'(dx);
      ay_q <= dy[AW-1] ? AW'(-dy) : AW'(dy);
    end
    if (state_q == ST_SQX && go_q && mul_sts.done) begin
      sqx_q <= mul_p[D2_W-1:0];
    end
    if (state_q == ST_SQY && go_q && mul_sts.done) begin
      d2_q <= sqx_q + mul_p[D2_W-1:0];
    end
    if (state_q == ST_LIM && go_q && mul_sts.done) begin
      lim2_q <= mul_p;
    end
    if (state_q == ST_SQRT && go_q && sqrt_sts.done) begin
      d_q  <= sqrt_root;
      ov_q <= (MW'(dfull) - MW'(sqrt_root)) >> 1;
    end
    if (state_q == ST_DIVX && go_q && div_sts.done) begin
      mx_q <= div_q[MW-1:0];
    end
    if (state_q == ST_DIVY && go_q && div_sts.done) begin
      my_q <= div_q[MW-1:0];
    end
  end

  // Output register
  logic [SLOT_W-1:0] out_slot_q;
  logic [POS_W-1:0]  out_x_q, out_y_q;
  logic              out_last_q;

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_slot_q <= SLOT_W'(i_q);
      out_x_q    <= rd_x_q;
      out_y_q    <= rd_y_q;
      out_last_q <= (i_q == last_q);
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_slot_o  = out_slot_q;
  assign new_x_o     = out_x_q;
  assign new_y_o     = out_y_q;
  assign last_o      = out_last_q;

  // Checks
  a_pair_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDI) |-> (i_q != j_q))
    else $error("pair read with equal slots");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULX) |-> (MW'(d_q) <= MW'(dfull)))
    else $error("distance above touching distance");

  a_emit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ELD && out_ld && i_q == last_q) |=> (state_q == ST_IDLE))
    else $error("sweep did not end after last ball");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_ELD))
    else $error("result word outside emit");

  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!mul_sts.busy && !sqrt_sts.busy && !div_sts.busy))
    else $error("serial unit busy while idle");

endmodule

// ===== dv/tb_circle_overlap_relaxation.sv =====
// ----------------------------------------------------------------------------
// tb_circle_overlap_relaxation: self-checking testbench for ball relaxation
// Loads ball positions, runs sweeps under several register settings and
// checks every emitted ball word against a cycle-free predictor kept here.
// ----------------------------------------------------------------------------
module tb_circle_overlap_relaxation;
  import cor_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 4000;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic              last;
  } ball_word_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    kind_i;
  logic [SLOT_W-1:0]       slot_i;
  logic signed [POS_W-1:0] pos_x_i;
  logic signed [POS_W-1:0] pos_y_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [SLOT_W-1:0]       out_slot_o;
  logic signed [POS_W-1:0] new_x_o;
  logic signed [POS_W-1:0] new_y_o;
  logic                    last_o;

  // Predictor state
  longint     pos_x_mem [16];
  longint     pos_y_mem [16];
  int         radius_reg;
  int         width_reg;
  int         height_reg;
  int         count_reg;
  ball_word_t pending_balls [$];

  int fail_count = 0;
  int burst_left;
  int idle_cycles = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  circle_overlap_relaxation dut (.*);

  // Clock
  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // Floor of the square root
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Ball outside the area in either axis, or beyond the position range
  function automatic bit off_limits(longint x, longint y);
    longint dia;
    longint px;
    longint py;
    dia = 2 * radius_reg;
    px = x / 256;
    py = y / 256;
    if (x > POS_MAX || y > POS_MAX) return 1'b1;
    return px < 0 || px > width_reg - dia || py < 0 || py > height_reg - dia;
  endfunction

  // Push one ordered pair apart by half the overlap each
  function automatic void push_apart(int i, int j);
    longint dx, dy, ax, ay, d2, dfull, d, ov, mx, my, nx, ny;
    dx = pos_x_mem[i] - pos_x_mem[j];
    dy = pos_y_mem[i] - pos_y_mem[j];
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    d2 = ax * ax + ay * ay;
    dfull = longint'(2 * radius_reg) << 8;
    if (d2 == 0 || d2 > dfull * dfull) return;
    d = longint'(root_floor(d2));
    ov = (dfull - d) >>> 1;
    mx = (ov * ax) / d;
    my = (ov * ay) / d;
    if (dx < 0) mx = -mx;
    if (dy < 0) my = -my;
    nx = pos_x_mem[i] + mx;
    ny = pos_y_mem[i] + my;
    if (!off_limits(nx, ny)) begin
      pos_x_mem[i] = nx;
      pos_y_mem[i] = ny;
    end
    nx = pos_x_mem[j] - mx;
    ny = pos_y_mem[j] - my;
    if (!off_limits(nx, ny)) begin
      pos_x_mem[j] = nx;
      pos_y_mem[j] = ny;
    end
  endfunction

  // Apply one accepted word and queue the ball words it produces
  function automatic void apply_word(logic kind, logic [SLOT_W-1:0] slot,
                                     logic signed [POS_W-1:0] x,
                                     logic signed [POS_W-1:0] y);
    int n;
    ball_word_t w;
    if (kind == KIND_LOAD) begin
      pos_x_mem[slot] = longint'(x);
      pos_y_mem[slot] = longint'(y);
      return;
    end
    n = count_reg > 16 ? 16 : count_reg;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (i != j) push_apart(i, j);
    for (int i = 0; i < n; i++) begin
      w.slot = SLOT_W'(i);
      w.x = pos_x_mem[i][POS_W-1:0];
      w.y = pos_y_mem[i][POS_W-1:0];
      w.last = (i + 1 == n);
      pending_balls.insert(pending_balls.size(), w);
    end
  endfunction

  // Offer one word, hold it until accepted, then continue the burst or gap
  task automatic send_word(logic kind, logic [SLOT_W-1:0] slot,
                           logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
    int gap;
    in_valid_i <= 1'b1;
    kind_i <= kind;
    slot_i <= slot;
    pos_x_i <= x;
    pos_y_i <= y;
    do @(posedge clk_i); while (in_stall_o);
    apply_word(kind, slot, x, y);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_ball(int slot, int x, int y);
    send_word(KIND_LOAD, SLOT_W'(slot), POS_W'(x), POS_W'(y));
  endtask

  task automatic sweep();
    send_word(KIND_SWEEP, SLOT_W'($urandom), POS_W'($urandom), POS_W'($urandom));
  endtask

  // Drop valid and wait until every queued ball word has come back
  task automatic drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_balls.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BALL_RADIUS: radius_reg = value & 8'hFF;
      CFG_AREA_WIDTH:  width_reg = value & 12'hFFF;
      CFG_AREA_HEIGHT: height_reg = value & 12'hFFF;
      default:         count_reg = value & 5'h1F;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_all(int r, int w, int h, int n);
    write_reg(CFG_BALL_RADIUS, r);
    write_reg(CFG_AREA_WIDTH, w);
    write_reg(CFG_AREA_HEIGHT, h);
    write_reg(CFG_BALL_COUNT, n);
  endtask

  // Load slots 0..n-1 around a random center so that most pairs touch
  task automatic load_cluster(int n);
    int r, cx, cy, span;
    r = radius_reg;
    span = 2 * r * 256;
    cx = (width_reg > 4 * r) ? $urandom_range(2 * r, width_reg - 2 * r) : 0;
    cy = (height_reg > 4 * r) ? $urandom_range(2 * r, height_reg - 2 * r) : 0;
    for (int s = 0; s < n; s++)
      load_ball(s, cx * 256 + $urandom_range(0, 2 * span) - span,
                cy * 256 + $urandom_range(0, 2 * span) - span);
  endtask

  // Every slot gets written here, so no later sweep reads an empty slot
  task automatic test_reset_defaults();
    load_ball(0, -262144, 262143);
    load_ball(1, 262143, -262144);
    for (int s = 2; s < 16; s++)
      load_ball(s, (100 + 30 * s) * 256 + $urandom_range(0, 255), 300 * 256 + 7 * s);
    sweep();
    drain();
  endtask

  task automatic test_coincident_balls();
    load_ball(2, 400 * 256, 300 * 256);
    load_ball(3, 400 * 256, 300 * 256);
    sweep();
    drain();
  endtask

  task automatic test_config_extremes();
    set_all(255, 4095, 4095, 16);
    load_cluster(16);
    sweep();
    drain();
    set_all(1, 4095, 4095, 1);
    sweep();
    drain();
    // Area smaller than a ball: every move is undone
    set_all(40, 50, 1, 4);
    load_cluster(4);
    sweep();
    drain();
    set_all(0, 1000, 800, 3);
    load_cluster(3);
    sweep();
    drain();
    set_all(12'hF30, 4095, 4095, 0);
    sweep();
    drain();
    set_all(20, 4095, 4095, 31);
    sweep();
    drain();
  endtask

  // Hold the output for a long stretch while words keep coming
  task automatic test_back_pressure();
    set_all(30, 600, 600, 4);
    load_cluster(4);
    hold_reqs++;
    sweep();
    load_cluster(4);
    sweep();
    drain();
  endtask

  task automatic test_random_clusters();
    int sent, n, r;
    sent = 0;
    while (sent < 40) begin
      r = $urandom_range(2, 60);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(2, 6);
      set_all(r, $urandom_range(4 * r + 20, 4095), $urandom_range(4 * r + 20, 4095), n);
      repeat ($urandom_range(1, 3)) begin
        load_cluster(n);
        sent += n;
        // Noise words anywhere in the full field ranges
        if ($urandom_range(0, 2) == 0) begin
          load_ball($urandom_range(0, 15), int'($urandom), int'($urandom));
          sent++;
        end
        sweep();
        sent++;
      end
      drain();
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    ball_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_balls.size() == 0) begin
        $error("unexpected ball word slot=%0d", out_slot_o);
        fail_count++;
      end else begin
        e = pending_balls.pop_front();
        if (out_slot_o !== e.slot) begin
          $error("out_slot expected %0d actual %0d", e.slot, out_slot_o);
          fail_count++;
        end
        if (new_x_o !== e.x) begin
          $error("new_x expected %h actual %h", e.x, new_x_o);
          fail_count++;
        end
        if (new_y_o !== e.y) begin
          $error("new_y expected %h actual %h", e.y, new_y_o);
          fail_count++;
        end
        if (last_o !== e.last) begin
          $error("last expected %0b actual %0b", e.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Output stall pattern, with one long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      stall_phase++;
      if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("circle_overlap_relaxation verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_LOAD;
    slot_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    burst_left = 0;
    radius_reg = RADIUS_RST;
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    count_reg = COUNT_RST;
    for (int s = 0; s < 16; s++) begin
      pos_x_mem[s] = 0;
      pos_y_mem[s] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_coincident_balls();
    test_config_extremes();
    test_back_pressure();
    test_random_clusters();
    drain();

    if (fail_count == 0 && pending_balls.size() == 0) begin
      $display("circle_overlap_relaxation verification clean");
    end else begin
      $display("circle_overlap_relaxation verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cor_pkg.sv
hdl/cor_mul.sv
hdl/cor_sqrt.sv
hdl/cor_div.sv
hdl/circle_overlap_relaxation.sv
dv/tb_circle_overlap_relaxation.sv
